### rtl/esync_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the decay table of the eyelid sync smoother.
package esync_pkg;

    localparam int VALUE_BITS      = 16;
    localparam int TIME_BITS       = 32;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);

    localparam int STR_W     = 7;
    localparam int TAU_W     = 20;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;

    localparam int FULL_STRENGTH = 100;
    localparam int SNAP_US       = 500000;
    localparam int MIN_DT_US     = 1000;
    localparam int NOMINAL_DT_US = 8333;
    localparam int DTU_W         = $clog2(SNAP_US + 1);

    // log2(e) in Q16; the Q16 exponent y = dt * LOG2E / tau
    localparam int LOG2E_Q16 = 94548;
    localparam int LOG2E_W   = 17;
    localparam int Q_FRAC    = 16;
    localparam int SHIFT_W   = 5;
    localparam int ONE_Q16   = 65536;
    localparam int ALPHA_W   = Q_FRAC + 1;

    // divider: dividend dt*LOG2E, divisor tau, quotient y up to the point where 2^-y is zero
    localparam int DIV_DW    = DTU_W + LOG2E_W;
    localparam int DIV_TW    = TAU_W;
    localparam int DIV_QW    = Q_FRAC + SHIFT_W;
    localparam int DIV_CNT_W = $clog2(DIV_QW);

    // blend divide by 100 as a reciprocal multiply
    localparam int BLEND_W       = VALUE_BITS + STR_W;
    localparam int BLEND_ROUND   = 50;
    localparam int DIV100_SHIFT  = 30;
    localparam int DIV100_MULT   = (2**DIV100_SHIFT + FULL_STRENGTH - 1) / FULL_STRENGTH;
    localparam int STEP_ROUND    = 32768;

    localparam int MUL_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRENGTH       = 3'd0,
        CFG_PRESERVE_WINKS = 3'd1,
        CFG_SYNC_MOST_OPEN = 3'd2,
        CFG_WINK_THRESHOLD = 3'd3,
        CFG_WINK_CONF_MIN  = 3'd4,
        CFG_WINK_DWELL_US  = 3'd5,
        CFG_CLOSE_TAU_US   = 3'd6,
        CFG_OPEN_TAU_US    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                  eyes_valid;
        logic [VALUE_BITS-1:0] openness_left;
        logic [VALUE_BITS-1:0] openness_right;
        logic [VALUE_BITS-1:0] confidence_left;
        logic [VALUE_BITS-1:0] confidence_right;
        logic [TIME_BITS-1:0]  time_us;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_BITS-1:0] out_left;
        logic [VALUE_BITS-1:0] out_right;
        logic                  wink_passed;
    } t_out_item;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [DIV_QW-1:0] quot;
    } t_div_res;

    typedef logic [EXP_TABLE_DEPTH-1:0][ALPHA_W-1:0] t_rom;

    // 2^(-j/EXP_TABLE_DEPTH) in Q16 from a truncated series of exp(-j*ln2/depth)
    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] term;
        for (int j = 0; j < EXP_TABLE_DEPTH; j++) begin
            t    = (64'(j) * 64'd2977044472) / EXP_TABLE_DEPTH;
            sum  = 64'd1 << 32;
            term = 64'd1 << 32;
            for (int k = 1; k <= 24; k++) begin
                term = ((term * t) >> 32) / 64'(k);
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            rom[j] = ALPHA_W'((sum + 64'd32768) >> 16);
        end
        return rom;
    endfunction

    localparam t_rom POW2_ROM = f_build_rom();

endpackage

### rtl/eyelid_sync_smoother_core.sv
`timescale 1ns / 1ps
// Top level of the eyelid sync smoother: sequencer, shared multiplier and state.
//
// Frames enter on i_valid/o_ready with payload i_data; one result per frame leaves on
// o_valid/i_ready with payload o_data. A transaction completes when valid and ready are
// both high at a rising edge. The block takes one frame at a time: o_ready is high only
// while the sequencer is idle.
// A bypass frame (eyes_valid low or strength zero) comes out raw through S_OUT and
// the output register. Any other frame runs a setup step and a dt*LOG2E multiply, then
// for each eye a blend (two passes through the shared 24x24 multiplier, skipped by a
// stable wink), one exponent division by tau in the radix-2 divider (a quotient bit per
// cycle), a decay table lookup and a final multiply. The divider sets the rate; a snap
// (dt over half a second) skips the division, the lookup and the final multiply.
// Results wait in an output register, so a stalled receiver holds only that one result;
// the sequencer waits for the register to free before it returns to idle.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once and are
// meant for idle periods. Synchronous active-low reset restores register defaults, the
// smoothers to one half and clears the wink and timestamp history.
module eyelid_sync_smoother_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  esync_pkg::t_in_item               i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output esync_pkg::t_out_item              o_data,
    input  logic                              i_cfg_we,
    input  logic [esync_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [esync_pkg::CFG_W-1:0]       i_cfg_data
);
    import esync_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_PREP  = 12'b0000_0000_0010,
        S_DTMUL = 12'b0000_0000_0100,
        S_BMUL  = 12'b0000_0000_1000,
        S_BREC  = 12'b0000_0001_0000,
        S_BFIN  = 12'b0000_0010_0000,
        S_TAU   = 12'b0000_0100_0000,
        S_DIV   = 12'b0000_1000_0000,
        S_EXP   = 12'b0001_0000_0000,
        S_SMUL  = 12'b0010_0000_0000,
        S_SFIN  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    // configuration
    logic [STR_W-1:0]      r_strength;
    logic                  r_preserve;
    logic                  r_sync_max;
    logic [VALUE_BITS-1:0] r_wink_thr;
    logic [VALUE_BITS-1:0] r_wink_conf;
    logic [TAU_W-1:0]      r_dwell;
    logic [TAU_W-1:0]      r_close_tau;
    logic [TAU_W-1:0]      r_open_tau;

    // filter state
    logic [VALUE_BITS-1:0] r_smooth_l, n_smooth_l;
    logic [VALUE_BITS-1:0] r_smooth_r, n_smooth_r;
    logic                  r_seeded, n_seeded;
    logic [TIME_BITS-1:0]  r_last_time, n_last_time;
    logic                  r_have_last, n_have_last;
    logic [TIME_BITS-1:0]  r_wink_start, n_wink_start;
    logic                  r_wink_timing, n_wink_timing;
    logic                  r_wink_stable, n_wink_stable;

    // sequencer and working registers
    t_state                r_state, n_state;
    logic                  r_eye, n_eye;
    logic                  r_out_valid, n_out_valid;
    t_in_item              r_in, n_in;
    t_out_item             r_res, n_res;
    t_out_item             r_out, n_out;
    logic [DTU_W-1:0]      r_dt_use, n_dt_use;
    logic                  r_snap, n_snap;
    logic                  r_wink, n_wink;
    logic [VALUE_BITS-1:0] r_target, n_target;
    logic [STR_W-1:0]      r_str, n_str;
    logic [DIV_DW-1:0]     r_dividend, n_dividend;
    logic                  r_blend_up, n_blend_up;
    logic [VALUE_BITS-1:0] r_b, n_b;
    logic                  r_up, n_up;
    logic [VALUE_BITS-1:0] r_diff, n_diff;
    logic [ALPHA_W-1:0]    r_alpha, n_alpha;
    logic [2*MUL_W-1:0]    r_prod;

    // combinational helpers
    logic [MUL_W-1:0]           mul_a, mul_b;
    logic [VALUE_BITS-1:0]      lid, cur, lo, hi, asym, blend_q, step, new_val;
    logic [TIME_BITS-1:0]       dt, elapsed;
    logic                       wink_cond, wink_now, commit;
    logic [TAU_W-1:0]           tau_sel, div_divisor;
    logic                       div_start;
    t_div_res                   div_res;
    logic [VALUE_BITS+EXP_IDX_W:0] idx_prod;
    logic [EXP_IDX_W:0]         idx_raw;
    logic [EXP_IDX_W-1:0]       exp_idx;
    logic [ALPHA_W-1:0]         decay;
    logic [ALPHA_W:0]           alpha_full;
    logic [ALPHA_W+VALUE_BITS-1:0] step_sum;

    esync_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_dividend),
        .i_divisor  (div_divisor),
        .o_res      (div_res)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_smooth_l    = r_smooth_l;
        n_smooth_r    = r_smooth_r;
        n_seeded      = r_seeded;
        n_last_time   = r_last_time;
        n_have_last   = r_have_last;
        n_wink_start  = r_wink_start;
        n_wink_timing = r_wink_timing;
        n_wink_stable = r_wink_stable;
        n_state       = r_state;
        n_eye         = r_eye;
        n_out_valid   = r_out_valid;
        n_in          = r_in;
        n_res         = r_res;
        n_out         = r_out;
        n_dt_use      = r_dt_use;
        n_snap        = r_snap;
        n_wink        = r_wink;
        n_target      = r_target;
        n_str         = r_str;
        n_dividend    = r_dividend;
        n_blend_up    = r_blend_up;
        n_b           = r_b;
        n_up          = r_up;
        n_diff        = r_diff;
        n_alpha       = r_alpha;
        mul_a         = '0;
        mul_b         = '0;
        div_start     = 1'b0;
        commit        = 1'b0;
        new_val       = r_b;
        wink_now      = 1'b0;

        lid = r_eye ? r_in.openness_right : r_in.openness_left;
        cur = r_eye ? r_smooth_r : r_smooth_l;
        lo  = (r_in.openness_left < r_in.openness_right) ? r_in.openness_left
                                                         : r_in.openness_right;
        hi  = (r_in.openness_left > r_in.openness_right) ? r_in.openness_left
                                                         : r_in.openness_right;
        asym      = hi - lo;
        wink_cond = (asym > r_wink_thr) && (r_in.confidence_left > r_wink_conf) &&
                    (r_in.confidence_right > r_wink_conf);
        dt        = r_have_last ? (r_in.time_us - r_last_time) : '0;
        elapsed   = r_in.time_us - r_wink_start;

        // falling value uses the close time constant, a zero tau counts as 1 us
        tau_sel     = (r_b < cur) ? r_close_tau : r_open_tau;
        div_divisor = (tau_sel == '0) ? TAU_W'(1) : tau_sel;

        blend_q = VALUE_BITS'(r_prod >> DIV100_SHIFT);

        idx_prod = (VALUE_BITS+EXP_IDX_W+1)'(div_res.quot[Q_FRAC-1:0]) *
                   (VALUE_BITS+EXP_IDX_W+1)'(EXP_TABLE_DEPTH);
        idx_raw  = idx_prod[VALUE_BITS+EXP_IDX_W:Q_FRAC];
        exp_idx  = (idx_raw >= (EXP_IDX_W+1)'(EXP_TABLE_DEPTH)) ?
                   EXP_IDX_W'(EXP_TABLE_DEPTH - 1) : idx_raw[EXP_IDX_W-1:0];
        decay    = div_res.ovf ? '0 :
                   (POW2_ROM[exp_idx] >> div_res.quot[DIV_QW-1:Q_FRAC]);
        alpha_full = (ALPHA_W+1)'(ONE_Q16) - {1'b0, decay};

        step_sum = r_prod[ALPHA_W+VALUE_BITS-1:0] + (ALPHA_W+VALUE_BITS)'(STEP_ROUND);
        step     = VALUE_BITS'(step_sum >> Q_FRAC);

        // free the output register once the receiver takes the transaction
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_in = i_data;
                    if (!i_data.eyes_valid || (r_strength == '0)) begin
                        n_res.out_left    = i_data.openness_left;
                        n_res.out_right   = i_data.openness_right;
                        n_res.wink_passed = 1'b0;
                        n_state           = S_OUT;
                    end else begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                n_last_time = r_in.time_us;
                n_have_last = 1'b1;
                if (!r_seeded) begin
                    n_smooth_l = r_in.openness_left;
                    n_smooth_r = r_in.openness_right;
                    n_seeded   = 1'b1;
                end
                // first asymmetric frame starts the dwell timer, a later one may settle it
                if (r_preserve) begin
                    if (wink_cond) begin
                        if (!r_wink_timing) begin
                            n_wink_timing = 1'b1;
                            n_wink_start  = r_in.time_us;
                            n_wink_stable = 1'b0;
                        end else if (!r_wink_stable && (elapsed >= r_dwell)) begin
                            n_wink_stable = 1'b1;
                        end
                        wink_now = n_wink_stable;
                    end else begin
                        n_wink_timing = 1'b0;
                        n_wink_start  = '0;
                        n_wink_stable = 1'b0;
                    end
                end
                n_wink   = wink_now;
                n_snap   = (dt > SNAP_US);
                n_dt_use = (dt < MIN_DT_US) ? DTU_W'(NOMINAL_DT_US) : dt[DTU_W-1:0];
                n_target = r_sync_max ? hi : lo;
                n_str    = (r_strength > STR_W'(FULL_STRENGTH)) ? STR_W'(FULL_STRENGTH)
                                                               : r_strength;
                n_eye    = 1'b0;
                n_state  = S_DTMUL;
            end
            S_DTMUL: begin
                mul_a   = MUL_W'(r_dt_use);
                mul_b   = MUL_W'(LOG2E_Q16);
                n_state = S_BMUL;
            end
            S_BMUL: begin
                if (!r_eye) begin
                    n_dividend = r_prod[DIV_DW-1:0];
                end
                // a stable wink tracks the raw value, otherwise blend toward the target
                if (r_wink) begin
                    n_b     = lid;
                    n_state = S_TAU;
                end else begin
                    n_blend_up = (r_target >= lid);
                    mul_a      = MUL_W'(r_str);
                    mul_b      = MUL_W'((r_target >= lid) ? (r_target - lid)
                                                          : (lid - r_target));
                    n_state    = S_BREC;
                end
            end
            S_BREC: begin
                mul_a   = MUL_W'(r_prod[BLEND_W-1:0] + BLEND_W'(BLEND_ROUND));
                mul_b   = MUL_W'(DIV100_MULT);
                n_state = S_BFIN;
            end
            S_BFIN: begin
                n_b     = r_blend_up ? (lid + blend_q) : (lid - blend_q);
                n_state = S_TAU;
            end
            S_TAU: begin
                if (r_snap) begin
                    commit  = 1'b1;
                    new_val = r_b;
                end else begin
                    n_up      = (r_b >= cur);
                    n_diff    = (r_b >= cur) ? (r_b - cur) : (cur - r_b);
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                n_alpha = alpha_full[ALPHA_W-1:0];
                n_state = S_SMUL;
            end
            S_SMUL: begin
                mul_a   = MUL_W'(r_alpha);
                mul_b   = MUL_W'(r_diff);
                n_state = S_SFIN;
            end
            S_SFIN: begin
                commit  = 1'b1;
                new_val = r_up ? (cur + step) : (cur - step);
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // write back one eye, then advance to the other eye or finish the frame
        if (commit) begin
            if (r_eye) begin
                n_smooth_r        = new_val;
                n_state           = S_OUT;
                n_res.wink_passed = r_wink;
                n_res.out_left    = r_wink ? r_in.openness_left : r_smooth_l;
                n_res.out_right   = r_wink ? r_in.openness_right : new_val;
            end else begin
                n_smooth_l = new_val;
                n_eye      = 1'b1;
                n_state    = S_BMUL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength  <= '0;
            r_preserve  <= 1'b0;
            r_sync_max  <= 1'b0;
            r_wink_thr  <= VALUE_BITS'(29491);
            r_wink_conf <= VALUE_BITS'(39322);
            r_dwell     <= TAU_W'(120000);
            r_close_tau <= TAU_W'(18000);
            r_open_tau  <= TAU_W'(70000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STRENGTH:       r_strength  <= i_cfg_data[STR_W-1:0];
                CFG_PRESERVE_WINKS: r_preserve  <= i_cfg_data[0];
                CFG_SYNC_MOST_OPEN: r_sync_max  <= i_cfg_data[0];
                CFG_WINK_THRESHOLD: r_wink_thr  <= i_cfg_data[VALUE_BITS-1:0];
                CFG_WINK_CONF_MIN:  r_wink_conf <= i_cfg_data[VALUE_BITS-1:0];
                CFG_WINK_DWELL_US:  r_dwell     <= i_cfg_data[TAU_W-1:0];
                CFG_CLOSE_TAU_US:   r_close_tau <= i_cfg_data[TAU_W-1:0];
                CFG_OPEN_TAU_US:    r_open_tau  <= i_cfg_data[TAU_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth_l    <= VALUE_BITS'(32768);
            r_smooth_r    <= VALUE_BITS'(32768);
            r_seeded      <= 1'b0;
            r_last_time   <= '0;
            r_have_last   <= 1'b0;
            r_wink_start  <= '0;
            r_wink_timing <= 1'b0;
            r_wink_stable <= 1'b0;
            r_state       <= S_IDLE;
            r_eye         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_smooth_l    <= n_smooth_l;
            r_smooth_r    <= n_smooth_r;
            r_seeded      <= n_seeded;
            r_last_time   <= n_last_time;
            r_have_last   <= n_have_last;
            r_wink_start  <= n_wink_start;
            r_wink_timing <= n_wink_timing;
            r_wink_stable <= n_wink_stable;
            r_state       <= n_state;
            r_eye         <= n_eye;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_res      <= n_res;
        r_out      <= n_out;
        r_dt_use   <= n_dt_use;
        r_snap     <= n_snap;
        r_wink     <= n_wink;
        r_target   <= n_target;
        r_str      <= n_str;
        r_dividend <= n_dividend;
        r_blend_up <= n_blend_up;
        r_b        <= n_b;
        r_up       <= n_up;
        r_diff     <= n_diff;
        r_alpha    <= n_alpha;
        r_prod     <= mul_a * mul_b;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("frame taken but sequencer did not leave idle");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide wait");

    a_smooth_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_PREP && r_state != S_TAU && r_state != S_SFIN)
        |=> ($stable(r_smooth_l) && $stable(r_smooth_r)))
        else $error("smoother state moved outside a write-back step");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_valid || i_ready)) |=> (o_valid && o_ready))
        else $error("finished frame not loaded into the output register");
`endif

endmodule

### rtl/esync_div.sv
`timescale 1ns / 1ps
// Restoring radix-2 divider for the smoother exponent, one quotient bit per cycle.
module esync_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [esync_pkg::DIV_DW-1:0]  i_dividend,
    input  logic [esync_pkg::DIV_TW-1:0]  i_divisor,
    output esync_pkg::t_div_res           o_res
);
    import esync_pkg::*;

    localparam int HI_W = DIV_DW - DIV_QW;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic                 r_ovf, n_ovf;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_TW-1:0]    r_rem, n_rem;
    logic [DIV_TW-1:0]    r_dvs, n_dvs;
    logic [DIV_QW-1:0]    r_shf, n_shf;
    logic [DIV_TW:0]      trial;
    logic [HI_W-1:0]      hi;
    logic                 qbit;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_ovf  = r_ovf;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_shf  = r_shf;
        qbit   = 1'b0;
        hi     = i_dividend[DIV_DW-1:DIV_QW];
        trial  = {r_rem, r_shf[DIV_QW-1]};
        if (i_start) begin
            n_dvs = i_divisor;
            n_rem = DIV_TW'(hi);
            n_shf = i_dividend[DIV_QW-1:0];
            n_cnt = DIV_CNT_W'(DIV_QW - 1);
            // quotient would not fit: the exponent is past the point where the decay is zero
            if (DIV_TW'(hi) >= i_divisor) begin
                n_ovf  = 1'b1;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_ovf  = 1'b0;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = DIV_TW'(trial - {1'b0, r_dvs});
                qbit  = 1'b1;
            end else begin
                n_rem = trial[DIV_TW-1:0];
            end
            n_shf = {r_shf[DIV_QW-2:0], qbit};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovf <= n_ovf;
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_shf <= n_shf;
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quot = r_shf;

endmodule
